// File: design/cde_pkg.sv
// shared constants and types for the circular deque engine
package cde_pkg;

    localparam int MAX_DEPTH_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MODE_W         = 3;
    localparam int CFG_W          = 5;
    localparam int CAP_RESET_DEF  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_QUERY      = 3'd4
    } mode_t;

endpackage

// File: design/cde_ram.sv
// generic ram, one write port and two registered read ports
module cde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                       rd_data_a,
    output logic [WIDTH-1:0]                       rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: design/circular_deque_engine_core.sv
// circular deque engine: double-ended queue in a ring store, top level
// a request is held in the input register, then its result in the output register once it advances
// throughput: one request per cycle while m_axis_tready does not stall the result, set by the single
// store write port and the two store read ports that fetch the new front and back words
// reset clears head, tail and count and sets the capacity to 16 (MAX_DEPTH if smaller);
// store contents stay undefined until written, no clearing pass
module circular_deque_engine_core #(
    parameter int MAX_DEPTH  = cde_pkg::MAX_DEPTH_DEF,
    parameter int DATA_WIDTH = cde_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [cde_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // mode, value
    input  logic [((cde_pkg::MODE_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // ok, front_value, back_value, empty_flag, full_flag
    output logic [((2 * DATA_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    import cde_pkg::*;

    localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW      = $clog2(MAX_DEPTH + 1);
    localparam int CMPW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int OUT_W   = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8;
    localparam int CAP_RST = (MAX_DEPTH < CAP_RESET_DEF) ? MAX_DEPTH : CAP_RESET_DEF;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i,
                                               input logic [CW-1:0] cap);
        logic [CW:0] nxt;
        nxt = (CW+1)'(i) + (CW+1)'(1);
        return (nxt >= (CW+1)'(cap)) ? '0 : nxt[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] capm1;
        capm1 = cap - CW'(1);
        return (i == '0 || (CW+1)'(i) > (CW+1)'(cap)) ? capm1[AW-1:0] : i - AW'(1);
    endfunction

    logic                  in_valid_reg;
    mode_t                 in_mode_reg;
    logic [DATA_WIDTH-1:0] in_value_reg;

    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         cap_reg, cap_next;

    logic                  out_valid_reg;
    logic                  ok_reg, ok_next;
    logic                  empty_reg, empty_next;
    logic                  full_reg, full_next;
    logic                  front_byp_reg, front_byp_next;
    logic [DATA_WIDTH-1:0] front_word_reg, front_word_next;
    logic                  back_byp_reg, back_byp_next;
    logic [DATA_WIDTH-1:0] back_word_reg, back_word_next;

    logic                  advance;
    logic                  full_now, empty_now;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         front_addr, back_addr;
    logic [DATA_WIDTH-1:0] rd_front, rd_back;
    logic [CMPW-1:0]       cfg_ext;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign full_now      = count_reg >= cap_reg;
    assign empty_now     = count_reg == '0;

    // operation decode and pointer update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        case (in_mode_reg)
            MODE_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next  = wrap_dec(head_reg, cap_reg);
                    wr_en      = 1'b1;
                    wr_addr    = head_next;
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_PUSH_BACK:
            begin
                if (full_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                    tail_next  = wrap_inc(tail_reg, cap_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_POP_FRONT:
            begin
                if (empty_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next  = wrap_inc(head_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                end
            end
            MODE_POP_BACK:
            begin
                if (empty_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    tail_next  = wrap_dec(tail_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    // result flags and store bypass
    always_comb
    begin
        empty_next      = count_next == '0;
        full_next       = count_next >= cap_reg;
        front_addr      = head_next;
        back_addr       = wrap_dec(tail_next, cap_reg);
        front_byp_next  = 1'b0;
        front_word_next = in_value_reg;
        back_byp_next   = 1'b0;
        back_word_next  = in_value_reg;
        if (empty_next)
        begin
            front_byp_next  = 1'b1;
            front_word_next = '1;
            back_byp_next   = 1'b1;
            back_word_next  = '1;
        end
        else
        begin
            front_byp_next = wr_en && (wr_addr == front_addr);
            back_byp_next  = wr_en && (wr_addr == back_addr);
        end
    end

    // capacity clamp, zero acts as one
    always_comb
    begin
        cfg_ext = CMPW'(cfg_wr_data);
        if (cfg_ext == '0)
        begin
            cap_next = CW'(1);
        end
        else if (cfg_ext > CMPW'(MAX_DEPTH))
        begin
            cap_next = CW'(MAX_DEPTH);
        end
        else
        begin
            cap_next = cfg_ext[CW-1:0];
        end
    end

    cde_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en && advance),
        .wr_addr   (wr_addr),
        .wr_data   (in_value_reg),
        .rd_en     (advance),
        .rd_addr_a (front_addr),
        .rd_addr_b (back_addr),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CW'(CAP_RST);
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                cap_reg   <= cap_next;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else if (advance)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg  <= mode_t'(s_axis_tdata[MODE_W-1:0]);
            in_value_reg <= s_axis_tdata[MODE_W +: DATA_WIDTH];
        end
        if (advance)
        begin
            ok_reg         <= ok_next;
            empty_reg      <= empty_next;
            full_reg       <= full_next;
            front_byp_reg  <= front_byp_next;
            front_word_reg <= front_word_next;
            back_byp_reg   <= back_byp_next;
            back_word_reg  <= back_word_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({full_reg,
                                   empty_reg,
                                   back_byp_reg ? back_word_reg : rd_back,
                                   front_byp_reg ? front_word_reg : rd_front,
                                   ok_reg});

endmodule
